// ===== rtl/iefc_pkg.sv =====
// Shared constants and types for the infrared edge frame capture core.
// No dependencies; imported by the core and by its port checker.
package iefc_pkg;

   // Default storage depth in entries
   localparam int MAX_EDGES_DEF = 64;

   // Field widths
   localparam int KIND_W      = 2;
   localparam int TIME_W      = 32;
   localparam int RSP_IDX_W   = 6;
   localparam int BUF_SIZE_W  = 7;
   localparam int EXP_CNT_W   = 7;
   localparam int GAP_THR_W   = 20;
   localparam int IDLE_MS_W   = 17;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 20;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] REG_BUFFER_SIZE      = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_EXPECTED_COUNT   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_GAP_THRESHOLD_US = 2'd2;
   localparam logic [CSR_IDX_W-1:0] REG_IDLE_TIMEOUT_MS  = 2'd3;

   // Register reset values
   localparam logic [BUF_SIZE_W-1:0] BUF_SIZE_RST = 7'd64;
   localparam logic [EXP_CNT_W-1:0]  EXP_CNT_RST  = 7'd64;
   localparam logic [GAP_THR_W-1:0]  GAP_THR_RST  = 20'd5500;
   localparam logic [IDLE_MS_W-1:0]  IDLE_MS_RST  = 17'd500;

   // Request commands
   localparam logic CMD_EDGE = 1'b0;
   localparam logic CMD_TICK = 1'b1;

   // One stored buffer entry
   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [TIME_W-1:0] t_us;
   } entry_type;

endpackage

// ===== rtl/ir_edge_frame_capture_core.sv =====
// Infrared edge frame capture core: working buffer and held frame in two memories.
// Depends on iefc_pkg for widths, register indexes, reset values and the entry type.
//
// Usage: the req channel carries one beat per pin edge (req_cmd = edge) or per service
// tick (req_cmd = tick). Edge beats are stored as (kind, time_us) entries and produce no
// rsp beats. A tick with a closed frame pending streams expected_count beats, at most
// MAX_EDGES, on rsp, entry_index counting from zero and rsp_last on the final beat;
// entries never written read as zero. The user must write registers through
// csr_we/csr_index/csr_wdata only while idle; the core itself does not enforce this.
// Sequencing: with no frame close, an edge passes through the edge write and check
// states. Each frame close walks the work memory one entry per cycle, copying into the
// held memory, and one edge can close up to three times. A tick without emission leaves
// the core in idle; with emission it streams one beat per cycle while rsp_ready stays
// high, paced by the held memory read port, which is registered.
// A stalled receiver holds the rsp beat in the output register and the next entry in the
// read stage; the held memory read pauses until the output register frees up.
// Reset (synchronous) clears control state, the per-entry valid bits of both memories
// (so all entries read as zero) and loads the register defaults; no clearing pass runs.
module ir_edge_frame_capture_core #(
   parameter int MAX_EDGES = iefc_pkg::MAX_EDGES_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   // request channel
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic                            req_cmd,
   input  logic [iefc_pkg::KIND_W-1:0]     req_edge_kind,
   input  logic [iefc_pkg::TIME_W-1:0]     req_time_us,
   input  logic [iefc_pkg::TIME_W-1:0]     req_time_ms,
   // response channel
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [iefc_pkg::KIND_W-1:0]     rsp_out_edge_kind,
   output logic [iefc_pkg::TIME_W-1:0]     rsp_out_time_us,
   output logic [iefc_pkg::RSP_IDX_W-1:0]  rsp_entry_index,
   output logic                            rsp_last,
   // register write port
   input  logic                            csr_we,
   input  logic [iefc_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [iefc_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import iefc_pkg::*;

   localparam int AW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
   localparam int CW = $clog2(MAX_EDGES + 1);
   localparam logic [CW-1:0] MAX_CNT = CW'(MAX_EDGES);

   // Sequencer states
   localparam int ST_W = 3;
   localparam logic [ST_W-1:0] ST_IDLE    = 3'd0;
   localparam logic [ST_W-1:0] ST_COPY    = 3'd1;
   localparam logic [ST_W-1:0] ST_EDGE_WR = 3'd2;
   localparam logic [ST_W-1:0] ST_CHECK   = 3'd3;
   localparam logic [ST_W-1:0] ST_EMIT    = 3'd4;

   // Configuration registers
   logic [BUF_SIZE_W-1:0] cfg_buf_size_ff;
   logic [EXP_CNT_W-1:0]  cfg_exp_cnt_ff;
   logic [GAP_THR_W-1:0]  cfg_gap_thr_ff;
   logic [IDLE_MS_W-1:0]  cfg_idle_ms_ff;

   // Control state
   logic [ST_W-1:0]      state_ff, state_in;
   logic [ST_W-1:0]      ret_ff, ret_in;
   logic [CW-1:0]        wi_ff, wi_in;
   logic [TIME_W-1:0]    prev_us_ff, prev_us_in;
   logic [TIME_W-1:0]    last_ms_ff, last_ms_in;
   logic                 pending_ff, pending_in;
   logic [MAX_EDGES-1:0] wv_ff, wv_in;
   logic [MAX_EDGES-1:0] hv_ff, hv_in;
   logic [CW-1:0]        cp_idx_ff, cp_idx_in;
   logic                 cp_wr_vld_ff, cp_wr_vld_in;
   logic [AW-1:0]        cp_wr_addr_ff, cp_wr_addr_in;
   logic [CW-1:0]        em_idx_ff, em_idx_in;
   logic                 s1_vld_ff, s1_vld_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   // Payload registers
   logic [KIND_W-1:0]    item_kind_ff, item_kind_in;
   logic [TIME_W-1:0]    item_us_ff, item_us_in;
   logic [AW-1:0]        s1_idx_ff, s1_idx_in;
   logic                 s1_hv_ff, s1_hv_in;
   logic                 s1_last_ff, s1_last_in;
   logic [KIND_W-1:0]    rsp_kind_ff, rsp_kind_in;
   logic [TIME_W-1:0]    rsp_us_ff, rsp_us_in;
   logic [RSP_IDX_W-1:0] rsp_idx_ff, rsp_idx_in;
   logic                 rsp_last_ff, rsp_last_in;

   // Memories and their ports
   entry_type work_mem [MAX_EDGES];
   entry_type held_mem [MAX_EDGES];
   logic      w_we, w_re, h_we, h_re;
   logic [AW-1:0] w_waddr, w_raddr, h_waddr, h_raddr;
   entry_type w_wdata, h_wdata, w_rdata_ff, h_rdata_ff;

   // Derived values
   logic [CW-1:0]        size_c, emit_n;
   logic [TIME_W-1:0]    gap_us, idle_ms;
   logic                 gap_close, timed_out, rsp_adv, issue;
   logic [MAX_EDGES-1:0] in_use;

   assign req_ready         = (state_ff == ST_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_out_edge_kind = rsp_kind_ff;
   assign rsp_out_time_us   = rsp_us_ff;
   assign rsp_entry_index   = rsp_idx_ff;
   assign rsp_last          = rsp_last_ff;

   // Clamp sizes to the storage depth
   assign size_c = (cfg_buf_size_ff > BUF_SIZE_W'(MAX_EDGES)) ? MAX_CNT : CW'(cfg_buf_size_ff);
   assign emit_n = (cfg_exp_cnt_ff > EXP_CNT_W'(MAX_EDGES)) ? MAX_CNT : CW'(cfg_exp_cnt_ff);

   // Gap and idle tests, modulo 2^32
   assign gap_us    = req_time_us - prev_us_ff;
   assign idle_ms   = req_time_ms - last_ms_ff;
   assign gap_close = gap_us > TIME_W'(cfg_gap_thr_ff);
   assign timed_out = idle_ms > TIME_W'(cfg_idle_ms_ff);

   // Entries below buffer_size
   always_comb begin
      for (int i = 0; i < MAX_EDGES; i++) begin
         in_use[i] = CW'(i) < size_c;
      end
   end

   // Output stage frees up when empty or draining
   assign rsp_adv = !rsp_valid_ff || rsp_ready;
   assign issue   = (state_ff == ST_EMIT) && (em_idx_ff < emit_n) && (!s1_vld_ff || rsp_adv);

   // Sequencer
   always_comb begin
      state_in      = state_ff;
      ret_in        = ret_ff;
      wi_in         = wi_ff;
      prev_us_in    = prev_us_ff;
      last_ms_in    = last_ms_ff;
      pending_in    = pending_ff;
      wv_in         = wv_ff;
      hv_in         = hv_ff;
      cp_idx_in     = cp_idx_ff;
      cp_wr_vld_in  = 1'b0;
      cp_wr_addr_in = cp_wr_addr_ff;
      em_idx_in     = em_idx_ff;
      item_kind_in  = item_kind_ff;
      item_us_in    = item_us_ff;
      w_we    = 1'b0;
      w_waddr = '0;
      w_wdata = '0;
      w_re    = 1'b0;
      w_raddr = '0;
      h_we    = 1'b0;
      h_waddr = '0;
      h_wdata = '0;
      h_re    = 1'b0;
      h_raddr = '0;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_cmd == CMD_EDGE) begin
                  item_kind_in = req_edge_kind;
                  item_us_in   = req_time_us;
                  prev_us_in   = req_time_us;
                  last_ms_in   = req_time_ms;
                  if (gap_close) begin
                     // close the frame before storing this edge
                     wi_in      = '0;
                     pending_in = 1'b1;
                     cp_idx_in  = '0;
                     ret_in     = ST_EDGE_WR;
                     state_in   = ST_COPY;
                  end else begin
                     state_in = ST_EDGE_WR;
                  end
               end else begin
                  if (pending_ff) begin
                     pending_in = 1'b0;
                     if (emit_n != '0) begin
                        em_idx_in = '0;
                        state_in  = ST_EMIT;
                     end else begin
                        hv_in = hv_ff & ~in_use;
                     end
                  end
                  if (timed_out) begin
                     wi_in      = '0;
                     pending_in = 1'b0;
                  end
               end
            end
         end

         ST_COPY: begin
            // read work entry, write it to the held memory in the next cycle
            if (cp_idx_ff < size_c) begin
               w_re          = 1'b1;
               w_raddr       = cp_idx_ff[AW-1:0];
               cp_idx_in     = cp_idx_ff + CW'(1);
               cp_wr_vld_in  = 1'b1;
               cp_wr_addr_in = cp_idx_ff[AW-1:0];
            end
            if (cp_wr_vld_ff) begin
               h_we    = 1'b1;
               h_waddr = cp_wr_addr_ff;
               h_wdata = wv_ff[cp_wr_addr_ff] ? w_rdata_ff : '0;
               hv_in[cp_wr_addr_ff] = 1'b1;
               wv_in[cp_wr_addr_ff] = 1'b0;
            end
            if (!(cp_idx_ff < size_c) && !cp_wr_vld_ff) begin
               state_in = ret_ff;
            end
         end

         ST_EDGE_WR: begin
            if (wi_ff < size_c) begin
               // store the edge in both buffers
               w_we    = 1'b1;
               w_waddr = wi_ff[AW-1:0];
               w_wdata = '{kind: item_kind_ff, t_us: item_us_ff};
               h_we    = 1'b1;
               h_waddr = wi_ff[AW-1:0];
               h_wdata = '{kind: item_kind_ff, t_us: item_us_ff};
               wv_in[wi_ff[AW-1:0]] = 1'b1;
               hv_in[wi_ff[AW-1:0]] = 1'b1;
               wi_in    = wi_ff + CW'(1);
               state_in = ST_CHECK;
            end else begin
               // buffer full: drop the edge and close
               wi_in      = '0;
               pending_in = 1'b1;
               cp_idx_in  = '0;
               ret_in     = ST_CHECK;
               state_in   = ST_COPY;
            end
         end

         ST_CHECK: begin
            if (EXP_CNT_W'(wi_ff) == cfg_exp_cnt_ff) begin
               pending_in = 1'b1;
               cp_idx_in  = '0;
               ret_in     = ST_IDLE;
               state_in   = ST_COPY;
            end else begin
               state_in = ST_IDLE;
            end
         end

         ST_EMIT: begin
            if (issue) begin
               h_re      = 1'b1;
               h_raddr   = em_idx_ff[AW-1:0];
               em_idx_in = em_idx_ff + CW'(1);
            end
            // all reads issued and the read stage drained: clear the held frame
            if ((em_idx_ff == emit_n) && !s1_vld_ff) begin
               hv_in    = hv_ff & ~in_use;
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Read stage and output register
   always_comb begin
      s1_idx_in   = s1_idx_ff;
      s1_hv_in    = s1_hv_ff;
      s1_last_in  = s1_last_ff;
      s1_vld_in   = rsp_adv ? 1'b0 : s1_vld_ff;
      if (issue) begin
         s1_vld_in  = 1'b1;
         s1_idx_in  = em_idx_ff[AW-1:0];
         s1_hv_in   = hv_ff[em_idx_ff[AW-1:0]];
         s1_last_in = (em_idx_ff + CW'(1)) == emit_n;
      end

      rsp_valid_in = rsp_valid_ff;
      rsp_kind_in  = rsp_kind_ff;
      rsp_us_in    = rsp_us_ff;
      rsp_idx_in   = rsp_idx_ff;
      rsp_last_in  = rsp_last_ff;
      if (rsp_adv) begin
         rsp_valid_in = s1_vld_ff;
         if (s1_vld_ff) begin
            rsp_kind_in = s1_hv_ff ? h_rdata_ff.kind : '0;
            rsp_us_in   = s1_hv_ff ? h_rdata_ff.t_us : '0;
            rsp_idx_in  = RSP_IDX_W'(s1_idx_ff);
            rsp_last_in = s1_last_ff;
         end
      end
   end

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_buf_size_ff <= BUF_SIZE_RST;
         cfg_exp_cnt_ff  <= EXP_CNT_RST;
         cfg_gap_thr_ff  <= GAP_THR_RST;
         cfg_idle_ms_ff  <= IDLE_MS_RST;
      end else if (csr_we) begin
         case (csr_index)
            REG_BUFFER_SIZE:      cfg_buf_size_ff <= csr_wdata[BUF_SIZE_W-1:0];
            REG_EXPECTED_COUNT:   cfg_exp_cnt_ff  <= csr_wdata[EXP_CNT_W-1:0];
            REG_GAP_THRESHOLD_US: cfg_gap_thr_ff  <= csr_wdata[GAP_THR_W-1:0];
            REG_IDLE_TIMEOUT_MS:  cfg_idle_ms_ff  <= csr_wdata[IDLE_MS_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         ret_ff       <= ST_IDLE;
         wi_ff        <= '0;
         prev_us_ff   <= '0;
         last_ms_ff   <= '0;
         pending_ff   <= 1'b0;
         wv_ff        <= '0;
         hv_ff        <= '0;
         cp_idx_ff    <= '0;
         cp_wr_vld_ff <= 1'b0;
         em_idx_ff    <= '0;
         s1_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ret_ff       <= ret_in;
         wi_ff        <= wi_in;
         prev_us_ff   <= prev_us_in;
         last_ms_ff   <= last_ms_in;
         pending_ff   <= pending_in;
         wv_ff        <= wv_in;
         hv_ff        <= hv_in;
         cp_idx_ff    <= cp_idx_in;
         cp_wr_vld_ff <= cp_wr_vld_in;
         em_idx_ff    <= em_idx_in;
         s1_vld_ff    <= s1_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      cp_wr_addr_ff <= cp_wr_addr_in;
      item_kind_ff  <= item_kind_in;
      item_us_ff    <= item_us_in;
      s1_idx_ff     <= s1_idx_in;
      s1_hv_ff      <= s1_hv_in;
      s1_last_ff    <= s1_last_in;
      rsp_kind_ff   <= rsp_kind_in;
      rsp_us_ff     <= rsp_us_in;
      rsp_idx_ff    <= rsp_idx_in;
      rsp_last_ff   <= rsp_last_in;
   end

   // Work buffer memory
   always_ff @(posedge clock) begin
      if (w_we) begin
         work_mem[w_waddr] <= w_wdata;
      end
      if (w_re) begin
         w_rdata_ff <= work_mem[w_raddr];
      end
   end

   // Held frame memory
   always_ff @(posedge clock) begin
      if (h_we) begin
         held_mem[h_waddr] <= h_wdata;
      end
      if (h_re) begin
         h_rdata_ff <= held_mem[h_raddr];
      end
   end

endmodule

// ===== rtl/iefc_checker.sv =====
// Port-level checker for the infrared edge frame capture core, bound to the capture core.
// Depends on iefc_pkg for field widths.
module iefc_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_ready,
   input logic                           rsp_valid,
   input logic                           rsp_ready,
   input logic [iefc_pkg::KIND_W-1:0]    rsp_out_edge_kind,
   input logic [iefc_pkg::TIME_W-1:0]    rsp_out_time_us,
   input logic [iefc_pkg::RSP_IDX_W-1:0] rsp_entry_index,
   input logic                           rsp_last
);
   import iefc_pkg::*;

   // No beat right after reset
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp beat valid right after reset");

   // Hold a stalled beat
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_time_us)
         && $stable(rsp_out_edge_kind) && $stable(rsp_entry_index) && $stable(rsp_last))
      else $error("stalled rsp beat changed");

   // Run beats follow back to back with rising index
   a_run_step: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last |=> rsp_valid
         && (rsp_entry_index == RSP_IDX_W'($past(rsp_entry_index) + 1'b1)))
      else $error("frame run index did not advance by one");

   // A beat right after the final entry of a run opens the next run
   a_run_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_last |=> !rsp_valid || (rsp_entry_index == '0))
      else $error("run after a final entry did not start at entry zero");

   // No request taken while a run is still streaming
   a_busy_run: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> !req_ready)
      else $error("request ready in the middle of a frame run");

endmodule

bind ir_edge_frame_capture_core iefc_checker u_iefc_checker (.*);
